### hw/rtl/adm_pkg.sv
// shared constants and types for the arcade drive mixer
`timescale 1ns / 1ps
`default_nettype none
package adm_pkg;

    localparam int AXIS_W = 16;
    localparam int DRV_W  = 18;
    localparam int DB_W   = 15;
    localparam int MAXO_W = 16;
    localparam int MAG_W  = 17;
    localparam int QUO_W  = 16;
    localparam int LANES  = 2;
    localparam int CFG_W  = 16;

    localparam logic [MAG_W-1:0]  Q_ONE       = 17'd32768;
    localparam logic [MAXO_W-1:0] MAXO_RESET  = 16'd32768;
    localparam logic [AXIS_W-1:0] AXIS_MIN    = 16'h8000;
    localparam logic [AXIS_W-1:0] AXIS_MAX    = 16'h7fff;

    typedef logic [0:0] t_cfg_idx;
    localparam t_cfg_idx CFG_DEADBAND    = 1'b0;
    localparam t_cfg_idx CFG_DRIVE_LIMIT = 1'b1;

    typedef logic [LANES-1:0][MAG_W-1:0] t_mag_pair;
    typedef logic [LANES-1:0][QUO_W-1:0] t_quo_pair;

    typedef struct packed {
        logic signed [DRV_W-1:0] left;
        logic signed [DRV_W-1:0] right;
        logic [MAG_W-1:0]        mag_l;
        logic [MAG_W-1:0]        mag_r;
        logic [MAG_W-1:0]        mag_m;
        logic                    norm;
    } t_mix;

endpackage
`default_nettype wire

### hw/rtl/adm_if.sv
// joystick and drive stream interfaces
`timescale 1ns / 1ps
`default_nettype none
interface adm_joy_if;
    logic                                valid;
    logic                                ready;
    logic signed [adm_pkg::AXIS_W-1:0]   turn_axis;
    logic signed [adm_pkg::AXIS_W-1:0]   raw_forward_axis;
    modport source (output valid, turn_axis, raw_forward_axis, input ready);
    modport sink   (input valid, turn_axis, raw_forward_axis, output ready);
endinterface

interface adm_drive_if;
    logic                                valid;
    logic                                ready;
    logic signed [adm_pkg::DRV_W-1:0]    left_drive;
    logic signed [adm_pkg::DRV_W-1:0]    right_drive;
    modport source (output valid, left_drive, right_drive, input ready);
    modport sink   (input valid, left_drive, right_drive, output ready);
endinterface
`default_nettype wire

### hw/rtl/arcade_drive_mixer_top.sv
// arcade drive mixer top level: deadband shaping, mixing, normalization
// throughput: one item per cycle while o_drive is not stalled, set by the bit-per-stage dividers
// each stage holds independently, so bubbles close up under stalls
// reset: synchronous active low, clears all valid bits, deadband 0,
// drive limit 32768
`timescale 1ns / 1ps
`default_nettype none
module arcade_drive_mixer_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire adm_pkg::t_cfg_idx           i_cfg_idx,
    input  wire logic [adm_pkg::CFG_W-1:0]   i_cfg_data,
    adm_joy_if.sink                          i_joy,
    adm_drive_if.source                      o_drive
);

    // configuration registers, to be written only while idle; the block does not enforce this
    logic [adm_pkg::DB_W-1:0]   r_deadband;
    logic [adm_pkg::MAXO_W-1:0] r_drive_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband    <= '0;
            r_drive_limit <= adm_pkg::MAXO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                adm_pkg::CFG_DEADBAND:    r_deadband    <= i_cfg_data[adm_pkg::DB_W-1:0];
                adm_pkg::CFG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front stage: forward negation (saturating) and axis magnitudes
    logic                                r_fv;
    logic                                en_f;
    adm_pkg::t_mag_pair                  r_f_mag;
    logic [adm_pkg::LANES-1:0]           r_f_neg;
    logic [adm_pkg::AXIS_W-1:0]          fwd;
    logic                                d0_ready;

    // most negative raw forward saturates to full positive
    assign fwd = (i_joy.raw_forward_axis == adm_pkg::AXIS_MIN)
                 ? adm_pkg::AXIS_MAX
                 : adm_pkg::AXIS_W'(-i_joy.raw_forward_axis);

    assign en_f        = !r_fv || d0_ready;
    assign i_joy.ready = en_f;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (en_f) begin
            r_fv <= i_joy.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_f) begin
            r_f_neg[0] <= i_joy.turn_axis[adm_pkg::AXIS_W-1];
            r_f_neg[1] <= fwd[adm_pkg::AXIS_W-1];
            r_f_mag[0] <= i_joy.turn_axis[adm_pkg::AXIS_W-1]
                ? adm_pkg::MAG_W'(-{i_joy.turn_axis[adm_pkg::AXIS_W-1], i_joy.turn_axis})
                : adm_pkg::MAG_W'({1'b0, i_joy.turn_axis});
            r_f_mag[1] <= fwd[adm_pkg::AXIS_W-1]
                ? adm_pkg::MAG_W'(-{fwd[adm_pkg::AXIS_W-1], fwd})
                : {1'b0, fwd};
        end
    end

    // deadband: inside it the divider sees a zero numerator, outside the rescale
    // (|a| - db) * 32768 / (32768 - db)
    adm_pkg::t_mag_pair         d0_n;
    logic [adm_pkg::MAG_W-1:0]  d0_d;
    logic [adm_pkg::MAG_W-1:0]  db_ext;

    assign db_ext = adm_pkg::MAG_W'(r_deadband);
    assign d0_d   = adm_pkg::Q_ONE - db_ext;
    always_comb begin
        for (int l = 0; l < adm_pkg::LANES; l++) begin
            d0_n[l] = (r_f_mag[l] <= db_ext) ? '0 : r_f_mag[l] - db_ext;
        end
    end

    logic                       d0_v;
    adm_pkg::t_quo_pair         d0_q;
    logic [adm_pkg::LANES-1:0]  d0_neg;
    logic                       mix_ready;

    adm_div #(
        .LANES (adm_pkg::LANES),
        .DW    (adm_pkg::MAG_W),
        .QW    (adm_pkg::QUO_W),
        .SBW   (adm_pkg::LANES)
    ) u_div_axis (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_fv),
        .o_ready (d0_ready),
        .i_n     (d0_n),
        .i_d     (d0_d),
        .i_sb    (r_f_neg),
        .o_valid (d0_v),
        .i_ready (mix_ready),
        .o_q     (d0_q),
        .o_sb    (d0_neg)
    );

    // mix left = y + x, right = x - y, then larger magnitude vs the drive limit
    logic           mix_v;
    adm_pkg::t_mix  mix;
    logic           d1_ready;

    adm_mix u_mix (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (d0_v),
        .o_ready       (mix_ready),
        .i_q           (d0_q),
        .i_neg         (d0_neg),
        .i_drive_limit (r_drive_limit),
        .o_valid       (mix_v),
        .i_ready       (d1_ready),
        .o_mix         (mix)
    );

    // normalization v * 32768 / m on magnitudes; skipped items divide 0 by 1
    localparam int SB1_W = 2 * adm_pkg::DRV_W + 1;

    adm_pkg::t_mag_pair         d1_n;
    logic [adm_pkg::MAG_W-1:0]  d1_d;
    logic [SB1_W-1:0]           d1_sb_in;
    logic                       d1_v;
    adm_pkg::t_quo_pair         d1_q;
    logic [SB1_W-1:0]           d1_sb;
    logic                       en_o;

    assign d1_n[0]  = mix.norm ? mix.mag_l : '0;
    assign d1_n[1]  = mix.norm ? mix.mag_r : '0;
    assign d1_d     = mix.norm ? mix.mag_m : adm_pkg::MAG_W'(1);
    assign d1_sb_in = {mix.left, mix.right, mix.norm};

    adm_div #(
        .LANES (adm_pkg::LANES),
        .DW    (adm_pkg::MAG_W),
        .QW    (adm_pkg::QUO_W),
        .SBW   (SB1_W)
    ) u_div_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mix_v),
        .o_ready (d1_ready),
        .i_n     (d1_n),
        .i_d     (d1_d),
        .i_sb    (d1_sb_in),
        .o_valid (d1_v),
        .i_ready (en_o),
        .o_q     (d1_q),
        .o_sb    (d1_sb)
    );

    // output register: reapply signs on normalized items
    logic                             r_ov;
    logic signed [adm_pkg::DRV_W-1:0] r_left, r_right;
    logic signed [adm_pkg::DRV_W-1:0] raw_l, raw_r, norm_l, norm_r;
    logic                             sel_norm;

    assign raw_l    = d1_sb[SB1_W-1 -: adm_pkg::DRV_W];
    assign raw_r    = d1_sb[adm_pkg::DRV_W:1];
    assign sel_norm = d1_sb[0];
    assign norm_l   = raw_l[adm_pkg::DRV_W-1] ? -$signed({2'b00, d1_q[0]})
                                              : $signed({2'b00, d1_q[0]});
    assign norm_r   = raw_r[adm_pkg::DRV_W-1] ? -$signed({2'b00, d1_q[1]})
                                              : $signed({2'b00, d1_q[1]});

    assign en_o = !r_ov || o_drive.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en_o) begin
            r_ov <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_left  <= sel_norm ? norm_l : raw_l;
            r_right <= sel_norm ? norm_r : raw_r;
        end
    end

    assign o_drive.valid       = r_ov;
    assign o_drive.left_drive  = r_left;
    assign o_drive.right_drive = r_right;

endmodule
`default_nettype wire

### hw/rtl/adm_div.sv
// pipelined restoring divider, one quotient bit per stage, n <= d
`timescale 1ns / 1ps
`default_nettype none
module adm_div #(
    parameter int LANES = 2,
    parameter int DW    = 17,
    parameter int QW    = 16,
    parameter int SBW   = 1
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [LANES-1:0][DW-1:0]    i_n,
    input  wire logic [DW-1:0]               i_d,
    input  wire logic [SBW-1:0]              i_sb,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [LANES-1:0][QW-1:0]         o_q,
    output logic [SBW-1:0]                   o_sb
);

    logic [QW:0]     r_v;
    logic [QW+1:0]   en;
    logic [DW-1:0]   r_r  [QW+1][LANES];
    logic [QW-1:0]   r_q  [QW+1][LANES];
    logic [DW-1:0]   r_d  [QW+1];
    logic [SBW-1:0]  r_sb [QW+1];
    logic [LANES-1:0] r_b;
    logic [DW-1:0]   n_r  [QW][LANES];
    logic [QW-1:0]   n_q  [QW][LANES];

    // stage moves when empty or when the next one moves
    assign en[QW+1] = i_ready;
    for (genvar s = 0; s <= QW; s++) begin : g_en
        assign en[s] = !r_v[s] || en[s+1];
    end

    always_comb begin
        logic [DW:0] trial;
        logic        shin;
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                shin  = (s == 0) ? r_b[l] : 1'b0;
                trial = {r_r[s][l], shin};
                if (trial >= {1'b0, r_d[s]}) begin
                    n_r[s][l] = DW'(trial - {1'b0, r_d[s]});
                    n_q[s][l] = {r_q[s][l][QW-2:0], 1'b1};
                end else begin
                    n_r[s][l] = DW'(trial);
                    n_q[s][l] = {r_q[s][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s <= QW; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int l = 0; l < LANES; l++) begin
                r_r[0][l] <= i_n[l] >> 1;
                r_b[l]    <= i_n[l][0];
                r_q[0][l] <= '0;
            end
            r_d[0]  <= i_d;
            r_sb[0] <= i_sb;
        end
        for (int s = 1; s <= QW; s++) begin
            if (en[s]) begin
                for (int l = 0; l < LANES; l++) begin
                    r_r[s][l] <= n_r[s-1][l];
                    r_q[s][l] <= n_q[s-1][l];
                end
                r_d[s]  <= r_d[s-1];
                r_sb[s] <= r_sb[s-1];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[QW];
    assign o_sb    = r_sb[QW];
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_q[l] = r_q[QW][l];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/adm_mix.sv
// sign restore, mix and threshold compare, two register stages
`timescale 1ns / 1ps
`default_nettype none
module adm_mix (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire adm_pkg::t_quo_pair            i_q,
    input  wire logic [adm_pkg::LANES-1:0]     i_neg,
    input  wire logic [adm_pkg::MAXO_W-1:0]    i_drive_limit,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output adm_pkg::t_mix                      o_mix
);

    logic                             r_va, r_vb;
    logic                             en_a, en_b;
    logic signed [adm_pkg::DRV_W-1:0] r_left, r_right;
    logic signed [adm_pkg::DRV_W-1:0] x_s, y_s;
    logic [adm_pkg::MAG_W-1:0]        mag_l, mag_r, mag_m;
    adm_pkg::t_mix                    r_mix;

    assign en_b = !r_vb || i_ready;
    assign en_a = !r_va || en_b;

    // lane 0 is turn, lane 1 is forward
    assign x_s = i_neg[0] ? -$signed({2'b00, i_q[0]}) : $signed({2'b00, i_q[0]});
    assign y_s = i_neg[1] ? -$signed({2'b00, i_q[1]}) : $signed({2'b00, i_q[1]});

    assign mag_l = r_left[adm_pkg::DRV_W-1]  ? adm_pkg::MAG_W'(-r_left)
                                             : adm_pkg::MAG_W'(r_left);
    assign mag_r = r_right[adm_pkg::DRV_W-1] ? adm_pkg::MAG_W'(-r_right)
                                             : adm_pkg::MAG_W'(r_right);
    assign mag_m = (mag_l >= mag_r) ? mag_l : mag_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) r_va <= i_valid;
            if (en_b) r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_left  <= y_s + x_s;
            r_right <= x_s - y_s;
        end
        if (en_b) begin
            r_mix.left  <= r_left;
            r_mix.right <= r_right;
            r_mix.mag_l <= mag_l;
            r_mix.mag_r <= mag_r;
            r_mix.mag_m <= mag_m;
            r_mix.norm  <= mag_m > {1'b0, i_drive_limit};
        end
    end

    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_mix   = r_mix;

endmodule
`default_nettype wire

### hw/rtl/adm_chk.sv
// port-level checker for the arcade drive mixer and its bind
`timescale 1ns / 1ps
`default_nettype none
module adm_chk (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_out_valid,
    input wire logic                             i_out_ready,
    input wire logic signed [adm_pkg::DRV_W-1:0] i_left,
    input wire logic signed [adm_pkg::DRV_W-1:0] i_right
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("drive item dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_left) && $stable(i_right))
        else $error("drive item changed while stalled");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("drive item shown right after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_left >= -18'sd65536) && (i_left <= 18'sd65536) &&
                        (i_right >= -18'sd65536) && (i_right <= 18'sd65536))
        else $error("drive command beyond two units");

endmodule

bind arcade_drive_mixer_top adm_chk u_adm_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_drive.valid),
    .i_out_ready (o_drive.ready),
    .i_left      (o_drive.left_drive),
    .i_right     (o_drive.right_drive)
);
`default_nettype wire
